// ===== sv/i2cm_pkg.sv =====
// shared types and constants for the i2c master memory access block
package i2cm_pkg;

    // bus phase of the transaction
    typedef enum logic [4:0] {
        ST_IDLE   = 5'd0,
        ST_START  = 5'd1,
        ST_DEVW   = 5'd2,
        ST_ADDRH  = 5'd3,
        ST_ADDRL  = 5'd4,
        ST_DATA   = 5'd5,
        ST_RSTART = 5'd6,
        ST_DEVR   = 5'd7,
        ST_RX     = 5'd8,
        ST_STOP   = 5'd9
    } phase_t;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_MEM_DEV = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CLK_DEV = 8'd1;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [6:0] MEM_DEV_RESET = 7'd80;
    localparam logic [6:0] CLK_DEV_RESET = 7'd81;

    // bit counter value of the acknowledge slot
    localparam logic [3:0] ACK_SLOT = 4'd8;

    // packed widths of the stream payloads
    localparam int unsigned S_TDATA_W = 48;
    localparam int unsigned M_TDATA_W = 16;

    typedef struct packed {
        logic [6:0] mem_dev;
        logic [6:0] clk_dev;
    } dev_addr_t;

    // one input item, unpacked
    typedef struct packed {
        logic        op;
        logic        device_select;
        logic        is_read;
        logic [14:0] mem_address;
        logic [7:0]  write_byte;
        logic [15:0] read_count;
        logic        sda_in;
    } in_item_t;

    // one result item
    typedef struct packed {
        logic       scl_level;
        logic       sda_release;
        logic       write_protect;
        logic       busy_res;
        logic       read_valid;
        logic [7:0] read_data;
        logic       read_last;
        logic       ack_missing;
    } result_t;

endpackage

// ===== sv/i2c_master_memory_access_top.sv =====
// top level of the i2c master memory access block
//
//  channel   dir  handshake              payload
//  s_        in   s_tvalid / s_tready    s_tuser = op, s_tdata = command and tick fields
//  m_        out  m_tvalid / m_tready    m_tuser = read_valid, m_tlast = read_last, m_tdata
//  cfg_      in   cfg_valid / cfg_ready  cfg_index, cfg_data (device addresses)
//
// one item per cycle: the state machine advances one step of a bus phase
// per accepted item and the result is registered in the same cycle
// the single result register is refilled while it is being taken, so stalls
// on the result side only hold the input side when the register is full and not taken
// reset (aresetn low, synchronous) returns the bus to idle and the addresses to defaults
module i2c_master_memory_access_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // device_select, is_read, mem_address, write_byte, read_count, sda_in, zero fill
    input  logic [i2cm_pkg::S_TDATA_W-1:0]      s_tdata,
    // op
    input  logic                                s_tuser,
    // result items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // scl_level, sda_release, write_protect, busy_res, read_data, ack_missing, zero fill
    output logic [i2cm_pkg::M_TDATA_W-1:0]      m_tdata,
    // read_valid
    output logic                                m_tuser,
    // read_last
    output logic                                m_tlast,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [i2cm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [i2cm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    i2cm_pkg::in_item_t  item;
    i2cm_pkg::dev_addr_t dev_addr;
    i2cm_pkg::result_t   result;
    i2cm_pkg::result_t   result_reg;
    logic                m_valid_reg;
    logic                accept;

    // unpack the input item
    assign item.op            = s_tuser;
    assign item.device_select = s_tdata[0];
    assign item.is_read       = s_tdata[1];
    assign item.mem_address   = s_tdata[16:2];
    assign item.write_byte    = s_tdata[24:17];
    assign item.read_count    = s_tdata[40:25];
    assign item.sda_in        = s_tdata[41];

    // take a new item whenever the result register is free or being emptied
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // configuration is always writable
    assign cfg_ready = 1'b1;

    i2cm_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .dev_addr (dev_addr)
    );

    i2cm_phase u_phase (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .item     (item),
        .dev_addr (dev_addr),
        .result   (result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = result_reg.read_valid;
    assign m_tlast  = result_reg.read_last;
    assign m_tdata  = {3'b000,
                       result_reg.ack_missing,
                       result_reg.read_data,
                       result_reg.busy_res,
                       result_reg.write_protect,
                       result_reg.sda_release,
                       result_reg.scl_level};

endmodule

// ===== sv/i2cm_cfg.sv =====
// device address registers written through the configuration channel
module i2cm_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               wr_en,
    input  logic [i2cm_pkg::CFG_INDEX_W-1:0]   wr_index,
    input  logic [i2cm_pkg::CFG_DATA_W-1:0]    wr_data,
    output i2cm_pkg::dev_addr_t                dev_addr
);

    logic [6:0] mem_dev_reg;
    logic [6:0] clk_dev_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_dev_reg <= i2cm_pkg::MEM_DEV_RESET;
            clk_dev_reg <= i2cm_pkg::CLK_DEV_RESET;
        end else if (wr_en) begin
            // indexes beyond the list fall through untouched
            if (wr_index == i2cm_pkg::REG_MEM_DEV) begin
                mem_dev_reg <= wr_data[6:0];
            end
            if (wr_index == i2cm_pkg::REG_CLK_DEV) begin
                clk_dev_reg <= wr_data[6:0];
            end
        end
    end

    assign dev_addr.mem_dev = mem_dev_reg;
    assign dev_addr.clk_dev = clk_dev_reg;

endmodule

// ===== sv/i2cm_phase.sv =====
// transaction state machine: one step of a bus phase per accepted item
module i2cm_phase (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  i2cm_pkg::in_item_t   item,
    input  i2cm_pkg::dev_addr_t  dev_addr,
    output i2cm_pkg::result_t    result
);

    i2cm_pkg::phase_t state_reg, state_next;
    logic [3:0]  bit_cnt_reg, bit_cnt_next;
    logic [7:0]  shift_reg, shift_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [14:0] addr_reg, addr_next;
    logic [9:0]  cmd_reg, cmd_next;
    logic        busy_reg, busy_next;
    logic [1:0]  quarter_reg, quarter_next;

    logic             do_enter;
    i2cm_pkg::phase_t enter_st;
    logic [6:0]       dev_sel_addr;
    logic             rv, rl, am;
    logic [7:0]       rd;
    logic [7:0]       shift_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= i2cm_pkg::ST_IDLE;
            bit_cnt_reg    <= '0;
            shift_reg      <= '0;
            bytes_left_reg <= '0;
            addr_reg       <= '0;
            cmd_reg        <= '0;
            busy_reg       <= 1'b0;
            quarter_reg    <= '0;
        end else if (accept) begin
            state_reg      <= state_next;
            bit_cnt_reg    <= bit_cnt_next;
            shift_reg      <= shift_next;
            bytes_left_reg <= bytes_left_next;
            addr_reg       <= addr_next;
            cmd_reg        <= cmd_next;
            busy_reg       <= busy_next;
            quarter_reg    <= quarter_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        bit_cnt_next    = bit_cnt_reg;
        shift_next      = shift_reg;
        bytes_left_next = bytes_left_reg;
        addr_next       = addr_reg;
        cmd_next        = cmd_reg;
        busy_next       = busy_reg;
        quarter_next    = quarter_reg;
        do_enter        = 1'b0;
        enter_st        = i2cm_pkg::ST_IDLE;
        rv              = 1'b0;
        rd              = '0;
        rl              = 1'b0;
        am              = 1'b0;
        shift_in        = {shift_reg[6:0], item.sda_in};

        if (item.op) begin
            if (!busy_reg) begin
                addr_next = item.mem_address;
                cmd_next  = {item.device_select, item.is_read, item.write_byte};
                if (item.is_read) begin
                    bytes_left_next = (item.read_count == '0) ? 16'd1 : item.read_count;
                end else begin
                    bytes_left_next = '0;
                end
                busy_next = 1'b1;
                do_enter  = 1'b1;
                enter_st  = i2cm_pkg::ST_START;
            end
        end else begin
            case (state_reg)
                i2cm_pkg::ST_IDLE: begin
                end
                i2cm_pkg::ST_START: begin
                    if (quarter_reg == 2'd0) begin
                        quarter_next = 2'd1;
                    end else begin
                        do_enter = 1'b1;
                        enter_st = i2cm_pkg::ST_DEVW;
                    end
                end
                i2cm_pkg::ST_RSTART: begin
                    if (quarter_reg < 2'd2) begin
                        quarter_next = quarter_reg + 2'd1;
                    end else begin
                        do_enter = 1'b1;
                        enter_st = i2cm_pkg::ST_DEVR;
                    end
                end
                i2cm_pkg::ST_STOP: begin
                    if (quarter_reg < 2'd2) begin
                        quarter_next = quarter_reg + 2'd1;
                    end else begin
                        state_next   = i2cm_pkg::ST_IDLE;
                        quarter_next = '0;
                        bit_cnt_next = '0;
                        busy_next    = 1'b0;
                    end
                end
                default: begin
                    // bit-level phases: scl low, then scl high
                    if (quarter_reg == 2'd0) begin
                        quarter_next = 2'd1;
                    end else if (!bit_cnt_reg[3]) begin
                        if (state_reg == i2cm_pkg::ST_RX) begin
                            shift_next = shift_in;
                        end
                        bit_cnt_next = bit_cnt_reg + 4'd1;
                        quarter_next = '0;
                        if (state_reg == i2cm_pkg::ST_RX && bit_cnt_reg == 4'd7) begin
                            rv = 1'b1;
                            rd = shift_in;
                            rl = (bytes_left_reg <= 16'd1);
                            if (bytes_left_reg != '0) begin
                                bytes_left_next = bytes_left_reg - 16'd1;
                            end
                        end
                    end else if (state_reg == i2cm_pkg::ST_RX) begin
                        do_enter = 1'b1;
                        enter_st = (bytes_left_reg != '0) ? i2cm_pkg::ST_RX
                                                           : i2cm_pkg::ST_STOP;
                    end else begin
                        am       = item.sda_in;
                        do_enter = 1'b1;
                        case (state_reg)
                            i2cm_pkg::ST_DEVW:  enter_st = cmd_reg[9] ? i2cm_pkg::ST_ADDRL
                                                                      : i2cm_pkg::ST_ADDRH;
                            i2cm_pkg::ST_ADDRH: enter_st = i2cm_pkg::ST_ADDRL;
                            i2cm_pkg::ST_ADDRL: enter_st = cmd_reg[8] ? i2cm_pkg::ST_RSTART
                                                                      : i2cm_pkg::ST_DATA;
                            i2cm_pkg::ST_DEVR:  enter_st = i2cm_pkg::ST_RX;
                            default:            enter_st = i2cm_pkg::ST_STOP;
                        endcase
                    end
                end
            endcase
        end

        // device address follows the latched select of the new command
        dev_sel_addr = cmd_next[9] ? dev_addr.clk_dev : dev_addr.mem_dev;

        if (do_enter) begin
            state_next   = enter_st;
            bit_cnt_next = '0;
            quarter_next = '0;
            case (enter_st)
                i2cm_pkg::ST_DEVW:  shift_next = {dev_sel_addr, 1'b0};
                i2cm_pkg::ST_DEVR:  shift_next = {dev_sel_addr, 1'b1};
                i2cm_pkg::ST_ADDRH: shift_next = {1'b0, addr_next[14:8]};
                i2cm_pkg::ST_ADDRL: shift_next = addr_next[7:0];
                i2cm_pkg::ST_DATA:  shift_next = cmd_next[7:0];
                i2cm_pkg::ST_RX:    shift_next = '0;
                default: begin
                end
            endcase
        end
    end

    // line levels of the phase now on the bus
    always_comb begin
        result.scl_level   = 1'b1;
        result.sda_release = 1'b1;
        case (state_next)
            i2cm_pkg::ST_START: begin
                result.scl_level   = 1'b1;
                result.sda_release = (quarter_next == 2'd0);
            end
            i2cm_pkg::ST_RSTART: begin
                result.scl_level   = (quarter_next != 2'd0);
                result.sda_release = (quarter_next != 2'd2);
            end
            i2cm_pkg::ST_STOP: begin
                result.scl_level   = (quarter_next != 2'd0);
                result.sda_release = (quarter_next == 2'd2);
            end
            i2cm_pkg::ST_DEVW, i2cm_pkg::ST_ADDRH, i2cm_pkg::ST_ADDRL,
            i2cm_pkg::ST_DATA, i2cm_pkg::ST_DEVR: begin
                result.scl_level   = quarter_next[0];
                result.sda_release = bit_cnt_next[3] ? 1'b1
                                                     : shift_next[~bit_cnt_next[2:0]];
            end
            i2cm_pkg::ST_RX: begin
                result.scl_level   = quarter_next[0];
                // master acks every byte but the last
                result.sda_release = bit_cnt_next[3] ? (bytes_left_next == '0) : 1'b1;
            end
            default: begin
                result.scl_level   = 1'b1;
                result.sda_release = 1'b1;
            end
        endcase

        result.write_protect = !(busy_next && cmd_next[9:8] == 2'b00);
        result.busy_res      = busy_next;
        result.read_valid    = rv;
        result.read_data     = rd;
        result.read_last     = rl;
        result.ack_missing   = am;
    end

endmodule

// ===== sv/i2cm_checker.sv =====
// port-level checks on the i2c master memory access block, bound to the top level
module i2cm_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [i2cm_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            m_tuser,
    input  logic                            m_tlast
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item dropped while stalled");

    // a received byte only arrives during a transaction
    a_read_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[3])
        else $error("read byte reported while not busy");

    // burst end only marks a received byte
    a_last_read: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("read_last without read_valid");

    // read data is zero unless a byte completed
    a_data_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[11:4] == 8'd0)
        else $error("read data not zero on a non-read item");

    // an ack slot and a completed byte never share an item
    a_ack_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[12] && m_tuser))
        else $error("ack_missing together with read_valid");

endmodule

bind i2c_master_memory_access_top i2cm_checker u_i2cm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
